@@ sv/sqe_pkg.sv @@
package sqe_pkg;

    localparam int WORD_BITS = 32;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_SWAP = 2'd2,
        KIND_LIST = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_LISTED     = 3'd1,
        STAT_LIST_EMPTY = 3'd2,
        STAT_POP_EMPTY  = 3'd3,
        STAT_SWAP_SHORT = 3'd4,
        STAT_PUSH_FULL  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_SWAP_RD,
        SQ_SWAP_WR1,
        SQ_SWAP_WR2,
        SQ_LIST
    } state_t;

    typedef struct packed {
        kind_t                        kind;
        logic signed [WORD_BITS-1:0]  push_value;
    } in_item_t;

    typedef struct packed {
        status_t                      status;
        logic signed [WORD_BITS-1:0]  entry_value;
        logic                         last;
    } out_item_t;

endpackage

@@ sv/stack_queue_engine.sv @@
// Bounded stack / queue of signed words held in a single-port RAM.
// Input channel s_valid/s_ready/s_data carries an item: kind (push, pop,
// swap, list) and push_value. Result channel m_valid/m_ready/m_data returns
// status, entry_value and last; last marks the final result of an item.
// cfg_wr_en/cfg_wr_data write queue_mode (0 stack, 1 queue); write only idle.
// Push, pop and every error result go into the output reg as the item is
// accepted, one item per cycle while m_ready does not stall the output.
// swap: the RAM port does read top, read next, write, write.
// list: one entry per cycle while m_ready does not stall the output; the
// first read is issued at accept, and the RAM read port sets this pace.
// s_ready is high only while the sequencer is idle and the output register
// is empty or being drained in the same cycle. A stall on m_ready holds the
// sequencer at its next output: a swap waits before its last write, and a
// pending list read is simply held in the RAM data reg.
// Reset (aresetn low, synchronous) empties the store and selects stack
// mode; RAM contents are not cleared, no clearing pass is needed since
// only written entries are ever read.
module stack_queue_engine #(
    parameter int DEPTH     = 32,
    parameter int DATA_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sqe_pkg::in_item_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sqe_pkg::out_item_t    m_data,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [DATA_BITS-1:0] mem [DEPTH];

    sqe_pkg::state_t      state_reg, state_next;
    logic [IW-1:0]        top_reg, top_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        ptr_reg, ptr_next;
    logic [CW-1:0]        left_reg, left_next;
    logic [DATA_BITS-1:0] hold_reg, hold_next;
    logic [DATA_BITS-1:0] rdata_reg;
    logic                 mode_reg;
    logic                 m_valid_reg;
    sqe_pkg::out_item_t   m_data_reg;

    logic                 mem_we, mem_re;
    logic [IW-1:0]        mem_addr;
    logic [DATA_BITS-1:0] mem_wdata;
    logic                 out_free, out_load;
    sqe_pkg::out_item_t   out_item;
    logic signed [DATA_BITS-1:0] rd_signed;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] p);
        return (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] p);
        return (p == '0) ? IW'(DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_add(input logic [IW-1:0] p,
                                              input logic [CW-1:0] c);
        logic [SW-1:0] s;
        s = SW'(p) + SW'(c);
        return (s >= SW'(DEPTH)) ? IW'(s - SW'(DEPTH)) : IW'(s);
    endfunction

    function automatic sqe_pkg::out_item_t short_result(input sqe_pkg::status_t st);
        sqe_pkg::out_item_t r;
        r.status      = st;
        r.entry_value = '0;
        r.last        = 1'b1;
        return r;
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == sqe_pkg::SQ_IDLE) && out_free;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign rd_signed = rdata_reg;

    always_comb begin
        state_next = state_reg;
        top_next   = top_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        left_next  = left_reg;
        hold_next  = hold_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = top_reg;
        mem_wdata  = s_data.push_value[DATA_BITS-1:0];
        out_load   = 1'b0;
        out_item   = short_result(sqe_pkg::STAT_OK);

        unique case (state_reg)
            sqe_pkg::SQ_IDLE: begin
                if (s_valid && out_free) begin
                    out_load = 1'b1;
                    unique case (s_data.kind)
                        sqe_pkg::KIND_PUSH: begin
                            if (count_reg == CW'(DEPTH)) begin
                                out_item = short_result(sqe_pkg::STAT_PUSH_FULL);
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (mode_reg) begin
                                    mem_addr = idx_add(top_reg, count_reg);
                                end else begin
                                    mem_addr = idx_dec(top_reg);
                                    top_next = idx_dec(top_reg);
                                end
                            end
                        end
                        sqe_pkg::KIND_POP: begin
                            if (count_reg == '0) begin
                                out_item = short_result(sqe_pkg::STAT_POP_EMPTY);
                            end else begin
                                top_next   = idx_inc(top_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        sqe_pkg::KIND_SWAP: begin
                            if (count_reg < CW'(2)) begin
                                out_item = short_result(sqe_pkg::STAT_SWAP_SHORT);
                            end else begin
                                out_load   = 1'b0;
                                mem_re     = 1'b1;
                                ptr_next   = idx_inc(top_reg);
                                state_next = sqe_pkg::SQ_SWAP_RD;
                            end
                        end
                        sqe_pkg::KIND_LIST: begin
                            if (count_reg == '0) begin
                                out_item = short_result(sqe_pkg::STAT_LIST_EMPTY);
                            end else begin
                                out_load   = 1'b0;
                                mem_re     = 1'b1;
                                ptr_next   = idx_inc(top_reg);
                                left_next  = count_reg;
                                state_next = sqe_pkg::SQ_LIST;
                            end
                        end
                    endcase
                end
            end
            sqe_pkg::SQ_SWAP_RD: begin
                // rdata holds the top entry; fetch the one below it
                hold_next  = rdata_reg;
                mem_re     = 1'b1;
                mem_addr   = ptr_reg;
                state_next = sqe_pkg::SQ_SWAP_WR1;
            end
            sqe_pkg::SQ_SWAP_WR1: begin
                mem_we     = 1'b1;
                mem_addr   = top_reg;
                mem_wdata  = rdata_reg;
                state_next = sqe_pkg::SQ_SWAP_WR2;
            end
            sqe_pkg::SQ_SWAP_WR2: begin
                if (out_free) begin
                    mem_we     = 1'b1;
                    mem_addr   = ptr_reg;
                    mem_wdata  = hold_reg;
                    out_load   = 1'b1;
                    state_next = sqe_pkg::SQ_IDLE;
                end
            end
            sqe_pkg::SQ_LIST: begin
                // next read is issued only when the current entry leaves
                if (out_free) begin
                    out_load             = 1'b1;
                    out_item.status      = sqe_pkg::STAT_LISTED;
                    out_item.entry_value = sqe_pkg::WORD_BITS'(rd_signed);
                    out_item.last        = (left_reg == CW'(1));
                    if (left_reg == CW'(1)) begin
                        state_next = sqe_pkg::SQ_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_addr  = ptr_reg;
                        ptr_next  = idx_inc(ptr_reg);
                        left_next = left_reg - 1'b1;
                    end
                end
            end
            default: begin
                state_next = sqe_pkg::SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sqe_pkg::SQ_IDLE;
            top_reg     <= '0;
            count_reg   <= '0;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            top_reg   <= top_next;
            count_reg <= count_next;
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg  <= ptr_next;
        left_reg <= left_next;
        hold_reg <= hold_next;
        if (out_load) begin
            m_data_reg <= out_item;
        end
    end

`ifndef SYNTH
    a_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.kind == sqe_pkg::KIND_PUSH
         && count_reg == CW'(DEPTH))
        |=> (m_valid && m_data.status == sqe_pkg::STAT_PUSH_FULL
             && $stable(count_reg) && $stable(top_reg)))
        else $error("push on full store changed state or gave wrong status");

    a_list_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == sqe_pkg::STAT_LISTED && !m_data.last)
        |-> (state_reg == sqe_pkg::SQ_LIST && left_reg != '0))
        else $error("list item without last but list sequencer not running");

    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != sqe_pkg::STAT_LISTED)
        |-> (m_data.entry_value == '0 && m_data.last))
        else $error("non-list result carries a value or misses last");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int SLOTS = 32;
    localparam int TAIL_CYCLES = 40;

    // Mirrors the circular store and checks the block's results in order.
    class entry_store_checker;
        logic signed [sqe_pkg::WORD_BITS-1:0] slot [SLOTS];
        logic [4:0] top_pos;
        int held;
        bit queue_mode;
        sqe_pkg::out_item_t due_results[$];
        int errors;

        function new();
            top_pos = '0;
            held = 0;
            queue_mode = 1'b0;
            errors = 0;
        endfunction

        function void add_due(sqe_pkg::status_t s, logic signed [sqe_pkg::WORD_BITS-1:0] v,
                              logic l);
            sqe_pkg::out_item_t r;
            r.status = s;
            r.entry_value = v;
            r.last = l;
            due_results.push_back(r);
        endfunction

        function void note_item(sqe_pkg::in_item_t item);
            logic [4:0] pos;
            logic [4:0] nxt;
            logic signed [sqe_pkg::WORD_BITS-1:0] tmp;
            case (item.kind)
                sqe_pkg::KIND_PUSH: begin
                    if (held >= SLOTS) begin
                        add_due(sqe_pkg::STAT_PUSH_FULL, '0, 1'b1);
                    end else begin
                        if (queue_mode) begin
                            pos = top_pos + 5'(held);
                        end else begin
                            top_pos = top_pos - 5'd1;
                            pos = top_pos;
                        end
                        slot[pos] = item.push_value;
                        held++;
                        add_due(sqe_pkg::STAT_OK, '0, 1'b1);
                    end
                end
                sqe_pkg::KIND_POP: begin
                    if (held == 0) begin
                        add_due(sqe_pkg::STAT_POP_EMPTY, '0, 1'b1);
                    end else begin
                        top_pos = top_pos + 5'd1;
                        held--;
                        add_due(sqe_pkg::STAT_OK, '0, 1'b1);
                    end
                end
                sqe_pkg::KIND_SWAP: begin
                    if (held < 2) begin
                        add_due(sqe_pkg::STAT_SWAP_SHORT, '0, 1'b1);
                    end else begin
                        nxt = top_pos + 5'd1;
                        tmp = slot[top_pos];
                        slot[top_pos] = slot[nxt];
                        slot[nxt] = tmp;
                        add_due(sqe_pkg::STAT_OK, '0, 1'b1);
                    end
                end
                default: begin
                    if (held == 0) begin
                        add_due(sqe_pkg::STAT_LIST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < held; i++) begin
                            pos = top_pos + 5'(i);
                            add_due(sqe_pkg::STAT_LISTED, slot[pos], (i == held - 1));
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(sqe_pkg::out_item_t got);
            sqe_pkg::out_item_t want;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected item status=%0d value=%0d last=%0b",
                         $time, got.status, got.entry_value, got.last);
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
            end
            if (got.entry_value !== want.entry_value) begin
                errors++;
                $display("%0t: entry_value expected %0d actual %0d",
                         $time, want.entry_value, got.entry_value);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last expected %0b actual %0b",
                         $time, want.last, got.last);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    sqe_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sqe_pkg::out_item_t m_data;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;

    logic [15:0] stall_mask = '1;
    logic [3:0] stall_tick = '0;
    int burst_left = 0;

    entry_store_checker board = new();

    stack_queue_engine dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Receiver: ready follows a 16-bit pattern, redrawn every lap; bit 0 is
    // always set so every lap gives ready at least once.
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 4'd1;
        if (stall_tick == 4'd15) begin
            case ($urandom_range(3))
                0: stall_mask <= '1;
                1: stall_mask <= 16'($urandom & $urandom) | 16'h0001;
                default: stall_mask <= 16'($urandom) | 16'h0001;
            endcase
        end
        m_ready <= stall_mask[stall_tick];
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_data);
        end
    end

    function automatic logic [sqe_pkg::WORD_BITS-1:0] random_word();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Drives one item, holds it until accepted, then maybe opens a gap.
    task automatic send_item(input sqe_pkg::kind_t k,
                             input logic [sqe_pkg::WORD_BITS-1:0] v);
        sqe_pkg::in_item_t item;
        int gap;
        item.kind = k;
        item.push_value = v;
        s_data <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_item(item);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(15);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.due_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_mode(input bit mode);
        wait_drained();
        cfg_wr_data <= mode;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.queue_mode = mode;
    endtask

    task automatic run_phase(input int push_pct, input int pop_pct, input int count);
        int r;
        sqe_pkg::kind_t k;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < push_pct) begin
                k = sqe_pkg::KIND_PUSH;
            end else if (r < push_pct + pop_pct) begin
                k = sqe_pkg::KIND_POP;
            end else begin
                k = r[0] ? sqe_pkg::KIND_SWAP : sqe_pkg::KIND_LIST;
            end
            send_item(k, random_word());
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty-store errors, extremes, swap and list in both modes
        write_mode(1'b0);
        send_item(sqe_pkg::KIND_LIST, 32'h0);
        send_item(sqe_pkg::KIND_POP, 32'h0);
        send_item(sqe_pkg::KIND_SWAP, 32'h0);
        send_item(sqe_pkg::KIND_PUSH, 32'h7FFF_FFFF);
        send_item(sqe_pkg::KIND_SWAP, 32'h0);
        send_item(sqe_pkg::KIND_LIST, 32'h0);
        send_item(sqe_pkg::KIND_PUSH, 32'h8000_0000);
        send_item(sqe_pkg::KIND_PUSH, 32'hFFFF_FFFF);
        send_item(sqe_pkg::KIND_PUSH, 32'h0000_0000);
        send_item(sqe_pkg::KIND_SWAP, 32'h0);
        send_item(sqe_pkg::KIND_LIST, 32'h0);
        send_item(sqe_pkg::KIND_POP, 32'h0);
        send_item(sqe_pkg::KIND_LIST, 32'h0);
        // mode change with entries held
        write_mode(1'b1);
        send_item(sqe_pkg::KIND_PUSH, 32'h5555_5555);
        send_item(sqe_pkg::KIND_PUSH, 32'hAAAA_AAAA);
        send_item(sqe_pkg::KIND_LIST, 32'h0);
        send_item(sqe_pkg::KIND_SWAP, 32'h0);
        send_item(sqe_pkg::KIND_POP, 32'h0);
        send_item(sqe_pkg::KIND_LIST, 32'h0);

        // random: fill to full, churn, drain past empty, churn again
        run_phase(92, 4, 36);
        send_item(sqe_pkg::KIND_LIST, 32'h0);
        write_mode(1'b0);
        run_phase(35, 35, 8);
        wait_drained();
        run_phase(35, 35, 8);
        write_mode(1'b1);
        run_phase(0, 95, 36);
        write_mode(1'b0);
        run_phase(40, 40, 8);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.errors == 0) begin
            $display("stack_queue_engine: match");
        end else begin
            $display("stack_queue_engine: mismatch");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("stack_queue_engine: mismatch");
        $finish;
    end

endmodule
